FILE: rtl/core/teq_pkg.sv
// Package for the timed event queue: sizes, opcodes, status codes and the
// request, result, probe and update types. Depends on nothing.
package teq_pkg;

    localparam int QUEUE_DEPTH   = 64;
    localparam int TRIGGER_DEPTH = 16;
    localparam int ID_BITS       = 10;

    localparam int TIME_W   = 64;
    localparam int ORD_W    = 16;
    localparam int TRF_W    = 32;
    localparam int HANDLE_W = 6;
    localparam int IDX_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CMP_W    = (IDX_W > HANDLE_W) ? IDX_W : HANDLE_W;
    localparam int TC_W     = $clog2(TRIGGER_DEPTH + 1);
    localparam int TI_W     = (TRIGGER_DEPTH > 1) ? $clog2(TRIGGER_DEPTH) : 1;

    localparam logic [3:0] OP_SCHED     = 4'd0;
    localparam logic [3:0] OP_SCHED_H   = 4'd1;
    localparam logic [3:0] OP_PUSH_TRIG = 4'd2;
    localparam logic [3:0] OP_NEXT      = 4'd3;
    localparam logic [3:0] OP_CANCEL    = 4'd4;
    localparam logic [3:0] OP_CANCEL_AT = 4'd5;
    localparam logic [3:0] OP_CANCEL_H  = 4'd6;
    localparam logic [3:0] OP_RESCHED   = 4'd7;
    localparam logic [3:0] OP_QUERY     = 4'd8;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_DROP     = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_PAST     = 3'd5;

    localparam logic [1:0] K_NONE  = 2'd0;
    localparam logic [1:0] K_TRIG  = 2'd1;
    localparam logic [1:0] K_EVENT = 2'd2;

    typedef struct packed {
        logic [3:0]          opcode;
        logic [TIME_W-1:0]   event_time;
        logic [ID_BITS-1:0]  source_id;
        logic                is_traffic;
        logic [HANDLE_W-1:0] handle_in;
    } t_in_req;

    typedef struct packed {
        logic [2:0]          status;
        logic [1:0]          kind;
        logic [ID_BITS-1:0]  out_id;
        logic [TIME_W-1:0]   out_time;
        logic [HANDLE_W-1:0] handle_out;
        logic                present;
    } t_out_res;

    // match key broadcast to every cell while a probe runs
    typedef struct packed {
        logic               any_src;
        logic               by_handle;
        logic               use_time;
        logic [ID_BITS-1:0] src;
        logic [TIME_W-1:0]  time_val;
        logic [CMP_W-1:0]   handle;
        logic [ORD_W-1:0]   counter;
    } t_key;

    // probe token handed from cell to cell
    typedef struct packed {
        logic               active;
        logic               found;
        logic [IDX_W-1:0]   idx;
        logic [TIME_W-1:0]  time_val;
        logic [ID_BITS-1:0] src;
        logic               traffic;
        logic [ORD_W-1:0]   age;
        logic               free_found;
        logic [IDX_W-1:0]   free_idx;
    } t_probe;

    // slot update broadcast to every cell
    typedef struct packed {
        logic               clr_en;
        logic [IDX_W-1:0]   clr_idx;
        logic               ins_en;
        logic [IDX_W-1:0]   ins_idx;
        logic [TIME_W-1:0]  ins_time;
        logic [ID_BITS-1:0] ins_src;
        logic               ins_traffic;
        logic [ORD_W-1:0]   ins_order;
    } t_upd;

endpackage

FILE: rtl/core/teq_if.sv
// Request and result channel interfaces of the timed event queue.
// Depends on teq_pkg.
interface teq_in_if;
    logic             valid;
    logic             ready;
    teq_pkg::t_in_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface teq_out_if;
    logic              valid;
    logic              ready;
    teq_pkg::t_out_res data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/teq_cell.sv
// One queue slot of the timed event queue and its stage of the probe chain.
// Depends on teq_pkg.
module teq_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [teq_pkg::IDX_W-1:0] i_idx,
    input  teq_pkg::t_key          i_key,
    input  teq_pkg::t_upd          i_upd,
    input  teq_pkg::t_probe        i_probe,
    output teq_pkg::t_probe        o_probe
);
    import teq_pkg::*;

    logic               r_valid;
    logic [TIME_W-1:0]  r_time;
    logic [ID_BITS-1:0] r_src;
    logic               r_traffic;
    logic [ORD_W-1:0]   r_order;
    t_probe             r_probe;
    t_probe             n_probe;
    logic [ORD_W-1:0]   w_age;
    logic               w_match;
    logic               w_better;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_upd.ins_en && i_upd.ins_idx == i_idx) begin
            r_valid <= 1'b1;
        end else if (i_upd.clr_en && i_upd.clr_idx == i_idx) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.ins_en && i_upd.ins_idx == i_idx) begin
            r_time    <= i_upd.ins_time;
            r_src     <= i_upd.ins_src;
            r_traffic <= i_upd.ins_traffic;
            r_order   <= i_upd.ins_order;
        end
    end

    always_comb begin
        w_age = i_key.counter - r_order;
        if (i_key.by_handle) begin
            w_match = r_valid && (CMP_W'(i_idx) == i_key.handle) && (r_src == i_key.src);
        end else begin
            w_match = r_valid && (i_key.any_src || r_src == i_key.src)
                      && (!i_key.use_time || r_time == i_key.time_val);
        end
        w_better = !i_probe.found || (r_time < i_probe.time_val)
                   || (r_time == i_probe.time_val && w_age > i_probe.age);
        n_probe = i_probe;
        if (i_probe.active && w_match && w_better) begin
            n_probe.found    = 1'b1;
            n_probe.idx      = i_idx;
            n_probe.time_val = r_time;
            n_probe.src      = r_src;
            n_probe.traffic  = r_traffic;
            n_probe.age      = w_age;
        end
        if (!r_valid && !i_probe.free_found) begin
            n_probe.free_found = 1'b1;
            n_probe.free_idx   = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= '0;
        end else begin
            r_probe <= n_probe;
        end
    end

    assign o_probe = r_probe;

endmodule

FILE: rtl/core/teq_ctrl.sv
// Sequencer of the timed event queue: takes requests, launches probes into
// the cell chain, applies slot updates and holds now, counters and triggers.
// Depends on teq_pkg and teq_if.
module teq_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [teq_pkg::TIME_W-1:0] i_cfg_wdata,
    teq_in_if.sink                     i_req,
    teq_out_if.source                  o_res,
    output teq_pkg::t_key              o_key,
    output teq_pkg::t_probe            o_probe,
    input  teq_pkg::t_probe            i_end,
    output teq_pkg::t_upd              o_upd
);
    import teq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]         r_state;
    logic [TIME_W-1:0]  r_end;
    logic [TIME_W-1:0]  r_now;
    logic [TRF_W-1:0]   r_tcnt;
    logic [ORD_W-1:0]   r_ord;
    logic [TC_W-1:0]    r_tcount;
    logic [ID_BITS-1:0] r_stack [TRIGGER_DEPTH];
    logic               r_launch;
    t_in_req            r_req;
    logic               r_past;
    logic               r_drop;
    logic               r_hok;
    t_out_res           r_res;
    logic               r_ov;
    t_out_res           r_out;

    logic               w_accept;
    logic               w_fin;
    logic [TC_W-1:0]    w_top;
    t_upd               w_upd;
    t_out_res           w_res;
    t_out_res           w_early;
    logic [TIME_W-1:0]  n_now;
    logic [TRF_W-1:0]   n_tcnt;
    logic [ORD_W-1:0]   n_ord;
    logic               w_ins_try;
    logic               w_ins_h;
    logic               w_free_ok;
    logic [IDX_W-1:0]   w_free_idx;
    logic [CMP_W-1:0]   w_hx;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_fin       = (r_state == S_SCAN) && i_end.active;
    assign w_top       = r_tcount - TC_W'(1);
    assign o_res.valid = r_ov;
    assign o_res.data  = r_out;

    always_comb begin
        o_key           = '0;
        o_key.src       = r_req.source_id;
        o_key.time_val  = r_req.event_time;
        o_key.handle    = CMP_W'(r_req.handle_in);
        o_key.counter   = r_ord;
        case (r_req.opcode)
            OP_NEXT:      o_key.any_src = 1'b1;
            OP_CANCEL_AT: o_key.use_time = 1'b1;
            OP_CANCEL_H:  o_key.by_handle = 1'b1;
            OP_QUERY: begin
                o_key.any_src  = 1'b1;
                o_key.use_time = 1'b1;
            end
            default:      o_key.any_src = 1'b0;
        endcase
        o_probe        = '0;
        o_probe.active = r_launch;
    end

    // result of requests that skip the probe: trigger push and pop, unknown opcodes
    always_comb begin
        w_early = '0;
        if (i_req.data.opcode == OP_PUSH_TRIG && r_tcount >= TC_W'(TRIGGER_DEPTH)) begin
            w_early.status = ST_FULL;
        end
        if (i_req.data.opcode == OP_NEXT && r_tcount != '0) begin
            w_early.kind     = K_TRIG;
            w_early.out_id   = r_stack[w_top[TI_W-1:0]];
            w_early.out_time = r_now;
        end
    end

    // close out a probe: pick the action and the result
    always_comb begin
        w_upd       = '0;
        w_res       = '0;
        n_now       = r_now;
        n_tcnt      = r_tcnt;
        n_ord       = r_ord;
        w_ins_try   = 1'b0;
        w_ins_h     = 1'b0;
        w_free_ok   = i_end.free_found;
        w_free_idx  = i_end.free_idx;
        case (r_req.opcode)
            OP_SCHED, OP_SCHED_H: begin
                w_ins_try = 1'b1;
                w_ins_h   = (r_req.opcode == OP_SCHED_H);
            end
            OP_NEXT: begin
                if (i_end.found) begin
                    w_upd.clr_en   = 1'b1;
                    w_upd.clr_idx  = i_end.idx;
                    if (i_end.traffic) begin
                        n_tcnt = r_tcnt - TRF_W'(1);
                    end
                    n_now          = i_end.time_val;
                    w_res.kind     = K_EVENT;
                    w_res.out_id   = i_end.src;
                    w_res.out_time = i_end.time_val;
                end else begin
                    w_res.status = ST_EMPTY;
                end
            end
            OP_CANCEL, OP_CANCEL_AT, OP_CANCEL_H: begin
                if (i_end.found) begin
                    w_upd.clr_en  = 1'b1;
                    w_upd.clr_idx = i_end.idx;
                    if (r_req.is_traffic) begin
                        n_tcnt = r_tcnt - TRF_W'(1);
                    end
                end else begin
                    w_res.status = ST_NOTFOUND;
                end
            end
            OP_RESCHED: begin
                if (i_end.found) begin
                    w_upd.clr_en  = 1'b1;
                    w_upd.clr_idx = i_end.idx;
                    if (r_req.is_traffic) begin
                        n_tcnt = r_tcnt - TRF_W'(1);
                    end
                    // the freed slot may now be the lowest free one
                    if (!i_end.free_found || i_end.idx < i_end.free_idx) begin
                        w_free_ok  = 1'b1;
                        w_free_idx = i_end.idx;
                    end
                end
                w_ins_try = 1'b1;
            end
            OP_QUERY: w_res.present = i_end.found;
            default:  w_res.status = ST_OK;
        endcase
        w_hx = CMP_W'(w_free_idx);
        if (w_ins_try) begin
            if (r_past) begin
                w_res.status = ST_PAST;
            end else if (r_drop || (w_ins_h && !r_hok)) begin
                w_res.status = ST_DROP;
            end else if (!w_free_ok) begin
                w_res.status = ST_FULL;
            end else begin
                w_upd.ins_en      = 1'b1;
                w_upd.ins_idx     = w_free_idx;
                w_upd.ins_time    = r_req.event_time;
                w_upd.ins_src     = r_req.source_id;
                w_upd.ins_traffic = r_req.is_traffic;
                w_upd.ins_order   = r_ord;
                n_ord             = r_ord + ORD_W'(1);
                if (w_ins_h && r_req.is_traffic) begin
                    n_tcnt = r_tcnt + TRF_W'(1);
                end
                w_res.handle_out = w_hx[HANDLE_W-1:0];
            end
        end
    end

    assign o_upd = w_fin ? w_upd : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_end    <= '0;
            r_now    <= '0;
            r_tcnt   <= '0;
            r_ord    <= '0;
            r_tcount <= '0;
            r_launch <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_end <= i_cfg_wdata;
            end
            r_launch <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_req.data.opcode)
                            OP_PUSH_TRIG: r_state <= S_DONE;
                            OP_NEXT: begin
                                if (r_tcount != '0) begin
                                    r_tcount <= w_top;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_launch <= 1'b1;
                                    r_state  <= S_SCAN;
                                end
                            end
                            OP_SCHED, OP_SCHED_H, OP_CANCEL, OP_CANCEL_AT,
                            OP_CANCEL_H, OP_RESCHED, OP_QUERY: begin
                                r_launch <= 1'b1;
                                r_state  <= S_SCAN;
                            end
                            default: r_state <= S_DONE;
                        endcase
                        if (i_req.data.opcode == OP_PUSH_TRIG
                            && r_tcount < TC_W'(TRIGGER_DEPTH)) begin
                            r_tcount <= r_tcount + TC_W'(1);
                        end
                    end
                end
                S_SCAN: begin
                    if (w_fin) begin
                        r_now   <= n_now;
                        r_tcnt  <= n_tcnt;
                        r_ord   <= n_ord;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ov || o_res.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_DONE && (!r_ov || o_res.ready)) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload: request copy, early checks, trigger stack, result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req  <= i_req.data;
            r_past <= i_req.data.event_time < r_now;
            r_drop <= (r_end != '0) && (i_req.data.event_time >= r_end);
            r_hok  <= i_req.data.is_traffic || (r_tcnt != '0 && !r_tcnt[TRF_W-1])
                      || (r_now == '0);
            r_res  <= w_early;
            if (i_req.data.opcode == OP_PUSH_TRIG && r_tcount < TC_W'(TRIGGER_DEPTH)) begin
                r_stack[r_tcount[TI_W-1:0]] <= i_req.data.source_id;
            end
        end else if (w_fin) begin
            r_res <= w_res;
        end
        if (r_state == S_DONE && (!r_ov || o_res.ready)) begin
            r_out <= r_res;
        end
    end

endmodule

FILE: rtl/core/timed_event_queue.sv
// Top level of the timed event queue: sequencer plus a chain of slot cells.
// Depends on teq_pkg, teq_if, teq_cell and teq_ctrl.
//
// A request carries an opcode and yields exactly one result. The queue is a
// row of QUEUE_DEPTH slot cells; every search (next, cancels, reschedule,
// query and the lowest free slot for a schedule) is a probe token that walks
// the row one cell per clock, each cell comparing its slot against the best
// candidate so far. A queue request therefore waits for the probe's trip
// along the whole cell row before its result is formed. Trigger push,
// trigger pop by next and unknown opcodes skip the probe. One request is
// in flight at a time; a finished result waits in the output register and
// the next request is taken as soon as the result has moved there.
// end_time is written through i_cfg_we / i_cfg_wdata; the user must write
// it only while the block is idle, the block itself does not enforce it.
module timed_event_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [teq_pkg::TIME_W-1:0] i_cfg_wdata,
    teq_in_if.sink                     i_req,
    teq_out_if.source                  o_res
);
    import teq_pkg::*;

    t_key   w_key;
    t_upd   w_upd;
    t_probe w_chain [QUEUE_DEPTH+1];

    teq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .o_res       (o_res),
        .o_key       (w_key),
        .o_probe     (w_chain[0]),
        .i_end       (w_chain[QUEUE_DEPTH]),
        .o_upd       (w_upd)
    );

    // slot cells; hand the probe along the row
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        teq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_key   (w_key),
            .i_upd   (w_upd),
            .i_probe (w_chain[g]),
            .o_probe (w_chain[g+1])
        );
    end

endmodule

FILE: rtl/core/teq_checker.sv
// Port-level checks of the timed event queue and their bind to the top.
// Depends on teq_pkg and timed_event_queue.
module teq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [2:0]                    i_status,
    input logic [1:0]                    i_kind,
    input logic [teq_pkg::ID_BITS-1:0]   i_out_id,
    input logic [teq_pkg::TIME_W-1:0]    i_out_time,
    input logic [teq_pkg::HANDLE_W-1:0]  i_handle_out
);
    import teq_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown right after reset");

    a_nothing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == K_NONE |-> i_out_id == '0 && i_out_time == '0)
        else $error("dispatch fields set with nothing dispatched");

    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_OK |-> i_kind == K_NONE && i_handle_out == '0)
        else $error("failed request dispatched or inserted");

endmodule

bind timed_event_queue teq_checker u_teq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_status     (o_res.data.status),
    .i_kind       (o_res.data.kind),
    .i_out_id     (o_res.data.out_id),
    .i_out_time   (o_res.data.out_time),
    .i_handle_out (o_res.data.handle_out)
);
